### rtl/core/kpt_pkg.sv
package kpt_pkg;

	// Fixed field widths
	localparam int ID_W  = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 7;

	// Defaults for the top-level parameters
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} kpt_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} kpt_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIX,
		S_DONE
	} kpt_state_t;

	// Control from the sequencer to the row of cells
	typedef struct packed {
		logic            shift;
		logic            load;
		logic [ID_W-1:0] load_id;
	} kpt_ring_t;

endpackage

### rtl/core/kpt_req_if.sv
interface kpt_req_if
	import kpt_pkg::*;
;
	logic             valid;
	logic             ready;
	kpt_op_t          operation;
	logic [ID_W-1:0]  key;
	logic [VAL_W-1:0] value;

	modport source (output valid, operation, key, value, input ready);
	modport sink (input valid, operation, key, value, output ready);
endinterface

### rtl/core/kpt_rsp_if.sv
interface kpt_rsp_if
	import kpt_pkg::*;
;
	logic             valid;
	logic             ready;
	kpt_status_t      status;
	logic [ID_W-1:0]  assigned_id;
	logic [VAL_W-1:0] read_value;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, status, assigned_id, read_value, entry_count, input ready);
	modport sink (input valid, status, assigned_id, read_value, entry_count, output ready);
endinterface

### rtl/core/kpt_cell.sv
module kpt_cell
	import kpt_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic                  load,
	input  logic [ID_W-1:0]       load_id,
	input  logic [DATA_WIDTH-1:0] load_data,
	input  logic [ID_W-1:0]       nb_id,
	input  logic [DATA_WIDTH-1:0] nb_data,
	output logic [ID_W-1:0]       id,
	output logic [DATA_WIDTH-1:0] data
);

	logic [ID_W-1:0]       id_q;
	logic [DATA_WIDTH-1:0] data_q;

	// One table slot: direct write wins, otherwise take the neighbor's entry
	always_ff @(posedge clk) begin
		if (load) begin
			id_q   <= load_id;
			data_q <= load_data;
		end else if (shift) begin
			id_q   <= nb_id;
			data_q <= nb_data;
		end
	end

	assign id   = id_q;
	assign data = data_q;

endmodule

### rtl/core/kpt_ctrl.sv
module kpt_ctrl
	import kpt_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	kpt_req_if.sink                     req,
	kpt_rsp_if.source                   rsp,
	input  logic [ID_W-1:0]             head_id,
	input  logic [DATA_WIDTH-1:0]       head_data,
	output kpt_ring_t                   ring,
	output logic [$clog2(CAPACITY)-1:0] load_slot,
	output logic [DATA_WIDTH-1:0]       load_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	kpt_state_t state_q, state_d;

	kpt_op_t               op_q;
	logic [ID_W-1:0]       key_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [ID_W-1:0]       next_id_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         rot_q;
	logic                  found_q;
	logic [IW-1:0]         slot_q;
	logic [DATA_WIDTH-1:0] hit_data_q;
	logic [ID_W-1:0]       last_id_q;
	logic [DATA_WIDTH-1:0] last_data_q;
	kpt_status_t           res_status_q;
	logic [ID_W-1:0]       res_id_q;
	logic [VAL_W-1:0]      res_rd_q;

	logic                  out_valid_q;
	kpt_status_t           out_status_q;
	logic [ID_W-1:0]       out_id_q;
	logic [VAL_W-1:0]      out_rd_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic req_xfer;
	logic out_free;
	logic full;
	logic rot_last;
	logic head_live;
	logic head_hit;
	logic head_is_last;

	assign req_xfer     = req.valid && req.ready;
	assign out_free     = !out_valid_q || rsp.ready;
	assign full         = (count_q >= CW'(CAPACITY));
	assign rot_last     = (rot_q == IW'(CAPACITY - 1));
	assign head_live    = (CW'(rot_q) < count_q);
	assign head_hit     = head_live && !found_q && (head_id == key_q);
	assign head_is_last = (count_q != '0) && (CW'(rot_q) == count_q - CW'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_REMOVE || op_q == OP_LOOKUP) state_d = S_SCAN;
				else state_d = S_DONE;
			end
			S_SCAN: begin
				if (rot_last) state_d = S_FIX;
			end
			S_FIX: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cell row control: rotate during a scan, write on add or on the swap
	always_comb begin
		ring.shift   = (state_q == S_SCAN);
		ring.load    = ((state_q == S_EXEC) && (op_q == OP_ADD) && !full) ||
		               ((state_q == S_FIX) && (op_q == OP_REMOVE) && found_q);
		ring.load_id = (state_q == S_EXEC) ? next_id_q : last_id_q;
		load_slot    = (state_q == S_EXEC) ? count_q[IW-1:0] : slot_q;
		load_data    = (state_q == S_EXEC) ? val_q : last_data_q;
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q  <= req.operation;
			key_q <= req.key;
			val_q <= DATA_WIDTH'(req.value);
		end
	end

	// Table state and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
			count_q   <= '0;
			rot_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_EXEC: begin
					rot_q   <= '0;
					found_q <= 1'b0;
					if (op_q == OP_ADD) begin
						next_id_q <= next_id_q + ID_W'(1);
						if (!full) count_q <= count_q + CW'(1);
					end else if (op_q == OP_CLEAR) begin
						count_q <= '0;
					end
				end
				S_SCAN: begin
					rot_q <= rot_q + IW'(1);
					if (head_hit) found_q <= 1'b1;
				end
				S_FIX: begin
					if (op_q == OP_REMOVE && found_q) count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Scan payload and result staging
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_EXEC: begin
				res_status_q <= ST_OK;
				res_id_q     <= '0;
				res_rd_q     <= '0;
				if (op_q == OP_ADD) begin
					res_id_q <= next_id_q;
					if (full) res_status_q <= ST_FULL;
				end
			end
			S_SCAN: begin
				if (head_hit) begin
					slot_q     <= rot_q;
					hit_data_q <= head_data;
				end
				if (head_is_last) begin
					last_id_q   <= head_id;
					last_data_q <= head_data;
				end
			end
			S_FIX: begin
				if (!found_q) res_status_q <= ST_MISS;
				else if (op_q == OP_LOOKUP) res_rd_q <= VAL_W'(hit_data_q);
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_rd_q     <= res_rd_q;
			out_cnt_q    <= CNT_W'(count_q);
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.assigned_id = out_id_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

### rtl/core/keyed_packed_table.sv
// Keyed packed table: up to CAPACITY entries of (32-bit id, DATA_WIDTH data).
// req channel: operation (add, remove, lookup, clear), key, value.
// rsp channel: status, assigned_id, read_value, entry_count; one per request.
// Add takes the next id of a running 32-bit counter and appends at the end.
// Remove and lookup search slots in order for the first matching id; remove
// moves the last entry into the freed slot.
// Entries live in a ring of cells. A search rotates the whole ring once, one
// slot past the head cell per cycle, so the ring is back home at the end.
// One request is in work at a time; the next one is taken in the cycle
// after the previous result enters the output register.
// The output register holds a result until rsp.ready; a new request may be
// taken meanwhile, but its result waits until the register is free.
// Reset (arst_n low) empties the table and sets the id counter to zero.
module keyed_packed_table
	import kpt_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	kpt_req_if.sink   req,
	kpt_rsp_if.source rsp
);

	localparam int IW = $clog2(CAPACITY);

	kpt_ring_t             ring;
	logic [IW-1:0]         load_slot;
	logic [DATA_WIDTH-1:0] load_data;
	logic [ID_W-1:0]       cell_id   [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	kpt_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.head_id   (cell_id[0]),
		.head_data (cell_data[0]),
		.ring      (ring),
		.load_slot (load_slot),
		.load_data (load_data)
	);

	// Ring of cells: each takes its upper neighbor, the last wraps to cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NB = (i + 1) % CAPACITY;

		kpt_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.shift     (ring.shift),
			.load      (ring.load && (load_slot == IW'(i))),
			.load_id   (ring.load_id),
			.load_data (load_data),
			.nb_id     (cell_id[NB]),
			.nb_data   (cell_data[NB]),
			.id        (cell_id[i]),
			.data      (cell_data[i])
		);
	end

endmodule

### tb/tb_keyed_packed_table.sv
`timescale 1ns / 1ps

module tb_keyed_packed_table;
	import kpt_pkg::*;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int DATA_WIDTH = DEF_DATA_WIDTH;
	localparam logic [VAL_W-1:0] DATA_MASK =
		(DATA_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << DATA_WIDTH) - 1);
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 50;

	// One expected response per accepted request
	typedef struct {
		kpt_op_t          op;
		kpt_status_t      status;
		logic [ID_W-1:0]  assigned_id;
		logic [VAL_W-1:0] read_value;
		logic [CNT_W-1:0] entry_count;
	} table_result_t;

	logic clk;
	logic arst_n;

	kpt_req_if req_ch ();
	kpt_rsp_if rsp_ch ();

	keyed_packed_table #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Mirror of the table contents
	logic [ID_W-1:0]  tbl_id [CAPACITY];
	logic [VAL_W-1:0] tbl_data [CAPACITY];
	int               tbl_count;
	logic [ID_W-1:0]  id_counter;

	table_result_t pending_results[$];
	int            err_count;
	int            cycle_cnt;

	// Idle controls for the sender and the receiver
	bit tx_gaps_on;
	bit rx_stalls_on;
	int hold_len;
	int hold_token;
	int hold_seen;
	int stall_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// First slot holding the key in slot order, -1 if none
	function automatic int find_entry(input logic [ID_W-1:0] key);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_id[i] == key)
				return i;
		end
		return -1;
	endfunction

	function automatic logic [ID_W-1:0] live_key();
		return tbl_id[$urandom_range(0, tbl_count - 1)];
	endfunction

	// Key that is not in the table: random, not handed out yet, or recently freed
	function automatic logic [ID_W-1:0] absent_key();
		logic [ID_W-1:0] k;
		do begin
			case ($urandom_range(0, 2))
				0: begin
					k = $urandom();
				end
				1: begin
					k = id_counter + ID_W'($urandom_range(0, 3));
				end
				default: begin
					k = id_counter - ID_W'($urandom_range(1, 80));
				end
			endcase
		end while (find_entry(k) >= 0);
		return k;
	endfunction

	// Apply one operation to the mirror and queue the response it must produce
	task automatic apply_table_op(input kpt_op_t op, input logic [ID_W-1:0] key,
		input logic [VAL_W-1:0] value);
		table_result_t res;
		int            slot;
		res.op          = op;
		res.status      = ST_OK;
		res.assigned_id = '0;
		res.read_value  = '0;
		case (op)
			OP_ADD: begin
				res.assigned_id = id_counter;
				if (tbl_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					tbl_id[tbl_count]   = id_counter;
					tbl_data[tbl_count] = value & DATA_MASK;
					tbl_count++;
				end
				id_counter = id_counter + 1'b1;
			end
			OP_REMOVE: begin
				slot = find_entry(key);
				if (slot < 0) begin
					res.status = ST_MISS;
				end else begin
					// last entry fills the hole; a no-op when it was the last slot
					tbl_count--;
					tbl_id[slot]   = tbl_id[tbl_count];
					tbl_data[slot] = tbl_data[tbl_count];
				end
			end
			OP_LOOKUP: begin
				slot = find_entry(key);
				if (slot < 0)
					res.status = ST_MISS;
				else
					res.read_value = tbl_data[slot];
			end
			default: begin
				tbl_count = 0;
			end
		endcase
		res.entry_count = CNT_W'(tbl_count);
		pending_results.push_back(res);
	endtask

	// Offer one request, wait for its transfer, then predict its response
	task automatic send_item(input kpt_op_t op, input logic [ID_W-1:0] key,
		input logic [VAL_W-1:0] value);
		int n;
		n = tx_gaps_on ? gap_len() : 0;
		repeat (n) begin
			@(negedge clk);
			req_ch.valid     <= 1'b0;
			req_ch.operation <= kpt_op_t'($urandom_range(0, 3));
			req_ch.key       <= $urandom();
			req_ch.value     <= $urandom();
		end
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.key       <= key;
		req_ch.value     <= value;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_table_op(op, key, value);
	endtask

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Receiver: random stalls plus long hold-offs requested by the tests
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen  = hold_token;
			stall_left = hold_len;
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
			stall_left = gap_len();
			rsp_ch.ready <= (stall_left == 0);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Response checker
	always @(posedge clk) begin
		table_result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response transfer with nothing outstanding");
			end else begin
				exp = pending_results.pop_front();
				if (rsp_ch.status !== exp.status)
					report_mismatch($sformatf("%s status got %0d want %0d",
						exp.op.name(), rsp_ch.status, exp.status));
				if (rsp_ch.assigned_id !== exp.assigned_id)
					report_mismatch($sformatf("%s assigned_id got %h want %h",
						exp.op.name(), rsp_ch.assigned_id, exp.assigned_id));
				if (rsp_ch.read_value !== exp.read_value)
					report_mismatch($sformatf("%s read_value got %h want %h",
						exp.op.name(), rsp_ch.read_value, exp.read_value));
				if (rsp_ch.entry_count !== exp.entry_count)
					report_mismatch($sformatf("%s entry_count got %0d want %0d",
						exp.op.name(), rsp_ch.entry_count, exp.entry_count));
			end
		end
	end

	// Watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d responses outstanding",
			cycle_cnt, pending_results.size());
		$display("status: fail");
		$finish;
	end

	// Empty table, field extremes, hits, misses, swap on remove, clear
	task automatic test_directed();
		logic [ID_W-1:0] base;
		base = id_counter;
		send_item(OP_CLEAR, '1, '1);
		send_item(OP_LOOKUP, '0, '0);
		send_item(OP_REMOVE, '1, $urandom());
		send_item(OP_ADD, $urandom(), '0);
		send_item(OP_ADD, $urandom(), '1);
		send_item(OP_ADD, '0, 32'ha5a5_5a5a);
		send_item(OP_ADD, '1, $urandom());
		send_item(OP_LOOKUP, base, $urandom());
		send_item(OP_LOOKUP, base + 1, '1);
		send_item(OP_LOOKUP, '1, '0);
		// first slot goes, the last entry moves into it
		send_item(OP_REMOVE, base, '0);
		send_item(OP_LOOKUP, base + 3, $urandom());
		// removing the entry that sits in the last slot
		send_item(OP_REMOVE, base + 2, $urandom());
		send_item(OP_REMOVE, base, $urandom());
		send_item(OP_LOOKUP, base + 2, $urandom());
		send_item(OP_ADD, $urandom(), $urandom());
		send_item(OP_CLEAR, $urandom(), $urandom());
		send_item(OP_LOOKUP, base + 1, $urandom());
		// id counter keeps running across a clear
		send_item(OP_ADD, $urandom(), $urandom());
		send_item(OP_CLEAR, '0, '0);
	endtask

	// Fill to capacity, then add into a full table and work around the edge
	task automatic test_full_table();
		logic [ID_W-1:0] overflow_id;
		while (tbl_count < CAPACITY)
			send_item(OP_ADD, $urandom(), $urandom());
		overflow_id = id_counter;
		repeat (3)
			send_item(OP_ADD, $urandom(), $urandom());
		send_item(OP_LOOKUP, tbl_id[CAPACITY-1], $urandom());
		send_item(OP_LOOKUP, overflow_id, $urandom());
		send_item(OP_REMOVE, tbl_id[0], $urandom());
		send_item(OP_ADD, $urandom(), $urandom());
		send_item(OP_ADD, $urandom(), $urandom());
		send_item(OP_REMOVE, tbl_id[CAPACITY/2], $urandom());
		send_item(OP_REMOVE, tbl_id[tbl_count-1], $urandom());
		send_item(OP_LOOKUP, live_key(), $urandom());
	endtask

	// Receiver holds off long while requests keep coming, so the input stalls
	task automatic test_backpressure();
		logic [ID_W-1:0] k;
		tx_gaps_on = 1'b0;
		hold_len   = 300;
		hold_token++;
		for (int i = 0; i < 14; i++) begin
			if (i % 3 == 0 || tbl_count == 0) begin
				send_item(OP_ADD, $urandom(), $urandom());
			end else begin
				k = $urandom_range(0, 1) ? live_key() : absent_key();
				send_item((i % 2) ? OP_LOOKUP : OP_REMOVE, k, $urandom());
			end
		end
		tx_gaps_on = 1'b1;
	endtask

	// Random mix in epochs that lean toward growing or shrinking the table
	task automatic test_random_mix(input int n_items);
		bit              grow;
		int              r;
		int              w_add;
		kpt_op_t         op;
		logic [ID_W-1:0] k;
		grow = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				grow         = $urandom_range(0, 2) != 0;
				tx_gaps_on   = $urandom_range(0, 3) != 0;
				rx_stalls_on = $urandom_range(0, 3) != 0;
			end
			r     = $urandom_range(0, 99);
			w_add = grow ? 60 : 25;
			if (r < w_add)
				op = OP_ADD;
			else if (r < w_add + 1)
				op = OP_CLEAR;
			else if (r < w_add + 1 + (99 - w_add) / 2)
				op = OP_REMOVE;
			else
				op = OP_LOOKUP;
			if ((op == OP_REMOVE || op == OP_LOOKUP) && tbl_count != 0
				&& $urandom_range(0, 3) != 0)
				k = live_key();
			else if (op == OP_REMOVE || op == OP_LOOKUP)
				k = absent_key();
			else
				k = $urandom();
			send_item(op, k, $urandom());
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_ADD;
		req_ch.key       = '0;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;
		tbl_count        = 0;
		id_counter       = '0;
		err_count        = 0;
		tx_gaps_on       = 1'b1;
		rx_stalls_on     = 1'b1;
		hold_len         = 0;
		hold_token       = 0;
		hold_seen        = 0;
		stall_left       = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_backpressure();
		test_random_mix(500);

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### keyed_packed_table.f
rtl/core/kpt_pkg.sv
rtl/core/kpt_req_if.sv
rtl/core/kpt_rsp_if.sv
rtl/core/kpt_cell.sv
rtl/core/kpt_ctrl.sv
rtl/core/keyed_packed_table.sv
tb/tb_keyed_packed_table.sv
